/* rtl/cpd_pkg.sv */
// Shared definitions for the CRC-16 packet deframer: frame constants, codes,
// the result record and the byte-wide CRC-16 update. No dependencies.
package cpd_pkg;

    localparam int unsigned HEADER_BYTES = 4;
    localparam int unsigned CNT_W        = 9;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_MSB  = 16'h8000;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Header byte positions within a buffer, and the position of the header check.
    localparam logic [CNT_W-1:0] IDX_MAGIC_FIRST  = CNT_W'(0);
    localparam logic [CNT_W-1:0] IDX_MAGIC_SECOND = CNT_W'(1);
    localparam logic [CNT_W-1:0] IDX_MSG_ID       = CNT_W'(2);
    localparam logic [CNT_W-1:0] IDX_LENGTH       = CNT_W'(3);
    localparam logic [CNT_W-1:0] IDX_HDR_CHECK    = CNT_W'(HEADER_BYTES + 1);

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_MAGIC_FIRST  = 2'd0,
        REG_MAGIC_SECOND = 2'd1,
        REG_MAX_PAYLOAD  = 2'd2
    } t_reg_index;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_VERDICT = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_FORMAT   = 2'd1,
        STATUS_OVERFLOW = 2'd2,
        STATUS_CRC      = 2'd3
    } t_status;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload_byte;
        logic [7:0]  message_id;
        logic [7:0]  payload_length;
        t_status     status;
    } t_result;

    // One byte through the CRC, MSB first; eight shift steps unrolled.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_MSB) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* rtl/crc16_packet_deframer.sv */
// Throughput: one input beat per cycle unless the input stalls; the frame state and CRC
// update in a single pass, and each result is registered before the master side.
// A skid register behind the result register holds one further result, so the input
// stalls only while two results are waiting on the master side.
// Reset (synchronous, active low) clears the frame state, empties both result registers
// and sets the magic bytes to zero and the payload limit to 255.
// Top level of the CRC-16 packet deframer. Depends on cpd_pkg.
module crc16_packet_deframer
    import cpd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration writes.
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // Raw buffer beats.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tlast,   // end_of_buffer
    // Results.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] payload_byte, [15:8] message_id,
                                        // [23:16] payload_length, [25:24] status
    output logic        m_axis_tuser    // result_kind
);

    logic [7:0] r_magic_first;
    logic [7:0] r_magic_second;
    logic [7:0] r_max_payload;

    logic [CNT_W-1:0] r_byte_count;
    logic [15:0]      r_crc;
    logic             r_magic_ok;
    logic [7:0]       r_msg_id;
    logic [7:0]       r_length;
    logic [7:0]       r_crc_low;
    logic             r_verdict_given;

    logic [CNT_W-1:0] n_byte_count;
    logic [15:0]      n_crc;
    logic             n_magic_ok;
    logic [7:0]       n_msg_id;
    logic [7:0]       n_length;
    logic [7:0]       n_crc_low;
    logic             n_verdict_given;

    t_result r_out;
    t_result r_skid;
    logic    r_out_valid;
    logic    r_skid_valid;

    logic       w_accept;
    logic       w_push;
    logic       w_pop;
    t_result    w_res;
    logic [CNT_W-1:0] w_body;
    logic       w_len_ok;
    logic       w_forward;

    assign s_axis_tready = !r_skid_valid;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_pop         = r_out_valid && m_axis_tready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic_first  <= 8'h00;
            r_magic_second <= 8'h00;
            r_max_payload  <= 8'hFF;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_MAGIC_FIRST:  r_magic_first  <= i_cfg_data;
                REG_MAGIC_SECOND: r_magic_second <= i_cfg_data;
                REG_MAX_PAYLOAD:  r_max_payload  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Frame tracking for one beat. The header fields take effect in the same beat
    // that carries them, so the body end is computed from the updated length.
    always_comb begin
        n_byte_count    = r_byte_count;
        n_crc           = r_crc;
        n_magic_ok      = r_magic_ok;
        n_msg_id        = r_msg_id;
        n_length        = r_length;
        n_crc_low       = r_crc_low;
        n_verdict_given = r_verdict_given;
        w_push          = 1'b0;
        w_res.kind           = KIND_PAYLOAD;
        w_res.payload_byte   = 8'h00;
        w_res.status         = STATUS_OK;

        if ((r_byte_count == IDX_MAGIC_FIRST) && (s_axis_tdata != r_magic_first)) begin
            n_magic_ok = 1'b0;
        end
        if ((r_byte_count == IDX_MAGIC_SECOND) && (s_axis_tdata != r_magic_second)) begin
            n_magic_ok = 1'b0;
        end
        if (r_byte_count == IDX_MSG_ID) begin
            n_msg_id = s_axis_tdata;
        end
        if (r_byte_count == IDX_LENGTH) begin
            n_length = s_axis_tdata;
        end

        w_body   = CNT_W'(HEADER_BYTES) + {1'b0, n_length};
        w_len_ok = (n_length <= r_max_payload);

        if (r_byte_count < w_body) begin
            n_crc = crc16_byte(r_crc, s_axis_tdata);
        end
        if (r_byte_count == w_body) begin
            n_crc_low = s_axis_tdata;
        end

        w_forward = (r_byte_count >= CNT_W'(HEADER_BYTES)) && (r_byte_count < w_body)
                    && n_magic_ok && w_len_ok;

        if ((r_byte_count == IDX_HDR_CHECK) && (!n_magic_ok || !w_len_ok)) begin
            w_push          = 1'b1;
            n_verdict_given = 1'b1;
            w_res.kind      = KIND_VERDICT;
            w_res.status    = n_magic_ok ? STATUS_OVERFLOW : STATUS_FORMAT;
        end else if (r_byte_count == w_body + CNT_W'(1)) begin
            w_push          = 1'b1;
            n_verdict_given = 1'b1;
            w_res.kind      = KIND_VERDICT;
            w_res.status    = ({s_axis_tdata, r_crc_low} == r_crc) ? STATUS_OK : STATUS_CRC;
        end else if (s_axis_tlast) begin
            // Short or truncated buffer.
            w_push          = 1'b1;
            n_verdict_given = 1'b1;
            w_res.kind      = KIND_VERDICT;
            w_res.status    = STATUS_FORMAT;
        end else if (w_forward) begin
            w_push             = 1'b1;
            w_res.payload_byte = s_axis_tdata;
        end

        if (r_byte_count != CNT_MAX) begin
            n_byte_count = r_byte_count + CNT_W'(1);
        end

        w_res.message_id     = n_msg_id;
        w_res.payload_length = n_length;

        // Once a verdict is out, beats are dropped until the end of the buffer.
        if (r_verdict_given) begin
            n_byte_count    = r_byte_count;
            n_crc           = r_crc;
            n_magic_ok      = r_magic_ok;
            n_msg_id        = r_msg_id;
            n_length        = r_length;
            n_crc_low       = r_crc_low;
            n_verdict_given = r_verdict_given;
            w_push          = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_accept && s_axis_tlast)) begin
            r_byte_count    <= '0;
            r_crc           <= CRC_INIT;
            r_magic_ok      <= 1'b1;
            r_msg_id        <= 8'h00;
            r_length        <= 8'h00;
            r_crc_low       <= 8'h00;
            r_verdict_given <= 1'b0;
        end else if (w_accept) begin
            r_byte_count    <= n_byte_count;
            r_crc           <= n_crc;
            r_magic_ok      <= n_magic_ok;
            r_msg_id        <= n_msg_id;
            r_length        <= n_length;
            r_crc_low       <= n_crc_low;
            r_verdict_given <= n_verdict_given;
        end
    end

    // Result register with a skid stage behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_pop || !r_out_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (w_accept && w_push) begin
            if (!r_out_valid || w_pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_pop || !r_out_valid) begin
                r_out <= r_skid;
            end
        end else if (w_accept && w_push) begin
            if (!r_out_valid || w_pop) begin
                r_out <= w_res;
            end else begin
                r_skid <= w_res;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = {6'b0, r_out.status, r_out.payload_length,
                            r_out.message_id, r_out.payload_byte};

    // The skid stage only ever holds a beat behind a full result register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a beat while the result register is empty");

    // No result is produced between a verdict and the end of its buffer.
    a_quiet_after_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_verdict_given) |-> !w_push)
        else $error("result produced after the verdict of this buffer");

    // The last beat of a buffer restarts the frame.
    a_restart_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && s_axis_tlast) |=> (r_byte_count == '0 && !r_verdict_given))
        else $error("frame state not cleared after the end of a buffer");

    // A verdict that does not end the buffer closes it until its last beat.
    a_verdict_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_push && w_res.kind == KIND_VERDICT && !s_axis_tlast)
        |=> r_verdict_given)
        else $error("verdict given but not recorded");

endmodule
